[hdl/tot_pkg.sv]
package tot_pkg;

   localparam int CITY_BITS = 6;
   localparam int RC_BITS   = 22;

   localparam logic [1:0] FUNC_COST = 2'd0;
   localparam logic [1:0] FUNC_TOUR = 2'd1;
   localparam logic [1:0] FUNC_RUN  = 2'd2;

   localparam logic [6:0] NUM_CITIES_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  from_city;
      logic [5:0]  to_city;
      logic [15:0] edge_cost;
      logic [5:0]  tour_index;
      logic [5:0]  tour_city;
      logic [21:0] start_cost;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_index;
      logic [5:0]  out_city;
      logic [21:0] final_cost;
      logic        last;
   } rsp_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_COPY  = 11'b00000000010,
      ST_PAIR  = 11'b00000000100,
      ST_RDA   = 11'b00000001000,
      ST_RDB   = 11'b00000010000,
      ST_ACC   = 11'b00000100000,
      ST_CMP   = 11'b00001000000,
      ST_SWAP  = 11'b00010000000,
      ST_DONE  = 11'b00100000000,
      ST_WB    = 11'b01000000000,
      ST_EMIT  = 11'b10000000000
   } state_type;

endpackage

[hdl/two_opt_tour_improver_core.sv]
// channel | ports                          | transfer
// req     | start, busy, req_payload       | start high and busy low
// rsp     | rsp_valid, rsp_payload         | one result per cycle, no stall
// csr     | psel penable pwrite paddr ...  | access phase, pready always high
// a run copies n tour entries, then evaluates each (i, j) pair through one matrix
// read port and reverses the segment of each pair that gains; an improved tour is
// written back, then n results follow one per cycle.
// reset is synchronous; the matrix and tour hold no reset.
// the receiver cannot stall; busy stays high from a run start to its last result.
module two_opt_tour_improver_core #(
   parameter int MAX_CITIES = 64,
   parameter int COST_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tot_pkg::req_type        req_payload,
   output logic                    rsp_valid,
   output tot_pkg::rsp_type        rsp_payload,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [1:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import tot_pkg::*;

   localparam int AW   = $clog2(MAX_CITIES);
   localparam int MW   = $clog2(MAX_CITIES*MAX_CITIES);
   localparam int PL   = (MAX_CITIES < 64) ? MAX_CITIES : 64;
   localparam int SUMW = COST_BITS + 8;
   localparam int GW   = (SUMW > RC_BITS + 2) ? SUMW : RC_BITS + 2;
   localparam logic [8:0] MAX_C9 = 9'(MAX_CITIES);

   // storage
   logic [COST_BITS-1:0] cost_mem [MAX_CITIES*MAX_CITIES];
   logic [CITY_BITS-1:0] tour_mem [MAX_CITIES];
   logic [CITY_BITS-1:0] w_ff [64];

   logic [6:0]  num_ff;
   logic [RC_BITS-1:0] rc_ff;
   state_type   st_ff, st_in;
   logic [6:0]  n_ff, i_ff, j_ff, k_ff, a_ff, b_ff;
   logic [1:0]  ph_ff;
   logic [SUMW-1:0] bef_ff, sw_ff;
   logic [GW-1:0] gain_ff;
   logic [RC_BITS-1:0] start_ff, fin_ff;
   logic [CITY_BITS-1:0] ca_ff, cb_ff;
   logic [COST_BITS-1:0] rd_ff;
   logic        rdok_ff;
   logic [CITY_BITS-1:0] city_ff;

   // config port
   assign pready = 1'b1;
   assign prdata = {25'd0, num_ff};
   always_ff @(posedge clock) begin
      if (reset) num_ff <= NUM_CITIES_RESET;
      else if (psel && penable && pwrite && paddr == 2'd0) num_ff <= pwdata[6:0];
   end

   logic acc;
   assign acc  = start && !busy;
   assign busy = (st_ff != ST_IDLE);

   // index helpers
   logic [6:0] kn, jn;
   assign kn = (k_ff + 7'd1 == n_ff) ? 7'd0 : k_ff + 7'd1;
   assign jn = (j_ff + 7'd1 == n_ff) ? 7'd0 : j_ff + 7'd1;

   // load writes and tour write-back
   always_ff @(posedge clock) begin
      if (acc && req_payload.func == FUNC_COST &&
          {3'd0, req_payload.from_city} < MAX_C9 &&
          {3'd0, req_payload.to_city} < MAX_C9)
         cost_mem[MW'(AW'(req_payload.from_city) * MAX_CITIES
                      + AW'(req_payload.to_city))]
            <= COST_BITS'(req_payload.edge_cost);
      if (acc && req_payload.func == FUNC_TOUR &&
          {3'd0, req_payload.tour_index} < MAX_C9)
         tour_mem[AW'(req_payload.tour_index)] <= req_payload.tour_city;
      else if (st_ff == ST_WB)
         tour_mem[AW'(k_ff)] <= w_ff[k_ff[5:0]];
   end

   // tour read for the result transfer, one position ahead
   always_ff @(posedge clock) begin
      city_ff <= tour_mem[AW'((st_ff == ST_EMIT) ? kn : 7'd0)];
   end

   // matrix read port, registered
   always_ff @(posedge clock) begin
      rd_ff   <= cost_mem[MW'(AW'(ca_ff) * MAX_CITIES + AW'(cb_ff))];
      rdok_ff <= ({3'd0, ca_ff} < MAX_C9) && ({3'd0, cb_ff} < MAX_C9);
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (acc && req_payload.func == FUNC_RUN) st_in = ST_COPY;
         ST_COPY: if (k_ff + 7'd1 == n_ff) st_in = ST_PAIR;
         ST_PAIR: begin
            if (j_ff < n_ff) st_in = ST_RDA;
            else if (i_ff + 7'd3 >= n_ff) st_in = ST_DONE;
         end
         ST_RDA:  st_in = ST_RDB;
         ST_RDB:  st_in = ST_ACC;
         ST_ACC:  st_in = (ph_ff == 2'd3) ? ST_CMP : ST_RDA;
         ST_CMP:  st_in = (sw_ff < bef_ff) ? ST_SWAP : ST_PAIR;
         ST_SWAP: if (a_ff + 7'd2 >= b_ff) st_in = ST_PAIR;
         ST_DONE: st_in = (fin_ff < start_ff) ? ST_WB : ST_EMIT;
         ST_WB:   if (k_ff + 7'd1 == n_ff) st_in = ST_EMIT;
         ST_EMIT: if (k_ff + 7'd1 == n_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   logic [SUMW-1:0] ev;
   assign ev = rdok_ff ? SUMW'(rd_ff) : '0;
   logic [GW-1:0] gsum;
   assign gsum = gain_ff + GW'(bef_ff - sw_ff);

   // datapath: the phases sum the before-sum edges, then the reversed edges, then edge i-j, then edge i+1-after
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rc_ff <= '0;
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            ST_IDLE: begin
               n_ff <= (num_ff < 7'd3) ? 7'd3 : (num_ff > 7'(PL)) ? 7'(PL) : num_ff;
               start_ff <= req_payload.start_cost;
               k_ff <= '0; i_ff <= '0; j_ff <= 7'd2; gain_ff <= '0;
            end
            ST_COPY: begin
               w_ff[k_ff[5:0]] <= tour_mem[AW'(k_ff)];
               k_ff <= k_ff + 7'd1;
            end
            ST_PAIR: begin
               if (j_ff >= n_ff) begin
                  i_ff <= i_ff + 7'd1; j_ff <= i_ff + 7'd3;
               end
               k_ff <= i_ff; ph_ff <= 2'd0; bef_ff <= '0; sw_ff <= '0;
            end
            ST_RDA: begin
               unique case (ph_ff)
                  2'd0: begin ca_ff <= w_ff[k_ff[5:0]]; cb_ff <= w_ff[kn[5:0]]; end
                  2'd1: begin ca_ff <= w_ff[k_ff[5:0]]; cb_ff <= w_ff[k_ff[5:0]-6'd1]; end
                  2'd2: begin ca_ff <= w_ff[i_ff[5:0]]; cb_ff <= w_ff[j_ff[5:0]]; end
                  default: begin
                     ca_ff <= w_ff[i_ff[5:0]+6'd1]; cb_ff <= w_ff[jn[5:0]];
                  end
               endcase
            end
            ST_RDB: ;
            ST_ACC: begin
               if (ph_ff == 2'd0) begin
                  bef_ff <= bef_ff + ev;
                  if (k_ff == j_ff) begin
                     ph_ff <= (j_ff >= i_ff + 7'd2) ? 2'd1 : 2'd2;
                  end else k_ff <= k_ff + 7'd1;
               end else begin
                  sw_ff <= sw_ff + ev;
                  if (ph_ff == 2'd1) begin
                     if (k_ff == i_ff + 7'd2) ph_ff <= 2'd2;
                     else k_ff <= k_ff - 7'd1;
                  end else if (ph_ff == 2'd2) ph_ff <= 2'd3;
               end
            end
            ST_CMP: begin
               a_ff <= i_ff + 7'd1; b_ff <= j_ff;
               if (sw_ff < bef_ff) gain_ff <= gsum;
               j_ff <= j_ff + 7'd1;
            end
            ST_SWAP: begin
               w_ff[a_ff[5:0]] <= w_ff[b_ff[5:0]];
               w_ff[b_ff[5:0]] <= w_ff[a_ff[5:0]];
               a_ff <= a_ff + 7'd1; b_ff <= b_ff - 7'd1;
            end
            ST_DONE: begin
               k_ff <= '0;
               rc_ff <= (fin_ff < start_ff) ? fin_ff : start_ff;
            end
            ST_WB: k_ff <= kn;
            ST_EMIT: k_ff <= k_ff + 7'd1;
            default: ;
         endcase
      end
      if (st_ff == ST_PAIR && j_ff >= n_ff && i_ff + 7'd3 >= n_ff)
         fin_ff <= (gain_ff >= GW'(start_ff)) ? '0
                   : RC_BITS'(GW'(start_ff) - gain_ff);
   end

   // result transfer
   assign rsp_valid              = (st_ff == ST_EMIT);
   assign rsp_payload.out_index  = k_ff[5:0];
   assign rsp_payload.out_city   = city_ff;
   assign rsp_payload.final_cost = rc_ff;
   assign rsp_payload.last       = (k_ff + 7'd1 == n_ff);
endmodule

[tb/sv/tb_two_opt_tour_improver_core.sv]
`timescale 1ns / 1ps

module tb_two_opt_tour_improver_core;
   import tot_pkg::*;

   // predicted tour contents, cost table and emitted results
   class tour_scoreboard;
      logic [15:0] cost_tab [64][64];
      logic [5:0]  tour_pos [64];
      int unsigned city_count;
      rsp_type     pending_rsp [$];
      int          errors;

      function new();
         city_count = 64;
         errors = 0;
      endfunction

      function logic [15:0] hop(logic [5:0] a, logic [5:0] b);
         return cost_tab[a][b];
      endfunction

      // note an accepted input item, queue the results of a run
      function void note_item(req_type r);
         logic [5:0]  w [64];
         logic [5:0]  t;
         longint unsigned gain, old_sum, new_sum, strt, fin;
         int n, a, b, after;
         rsp_type o;
         if (r.func == FUNC_COST) begin
            cost_tab[r.from_city][r.to_city] = r.edge_cost;
            return;
         end
         if (r.func == FUNC_TOUR) begin
            tour_pos[r.tour_index] = r.tour_city;
            return;
         end
         if (r.func != FUNC_RUN) return;
         n = int'(city_count);
         if (n < 3) n = 3;
         if (n > 64) n = 64;
         strt = r.start_cost;
         gain = 0;
         for (int k = 0; k < n; k++) w[k] = tour_pos[k];
         for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 2; j < n; j++) begin
               after = (j + 1 == n) ? 0 : j + 1;
               old_sum = 0;
               new_sum = 0;
               for (int k = i; k <= j; k++)
                  old_sum += hop(w[k], w[(k + 1 == n) ? 0 : k + 1]);
               for (int k = j; k >= i + 2; k--)
                  new_sum += hop(w[k], w[k - 1]);
               new_sum += hop(w[i], w[j]);
               new_sum += hop(w[i + 1], w[after]);
               if (new_sum < old_sum) begin
                  a = i + 1;
                  b = j;
                  while (a < b) begin
                     t = w[a]; w[a] = w[b]; w[b] = t;
                     a++; b--;
                  end
                  gain += old_sum - new_sum;
               end
            end
         end
         fin = (gain >= strt) ? 0 : strt - gain;
         if (fin < strt) begin
            for (int k = 0; k < n; k++) tour_pos[k] = w[k];
         end else begin
            fin = strt;
         end
         for (int k = 0; k < n; k++) begin
            o.out_index  = 6'(k);
            o.out_city   = tour_pos[k];
            o.final_cost = fin[21:0];
            o.last       = (k + 1 == n);
            pending_rsp.push_back(o);
         end
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_result(rsp_type got);
         rsp_type exp_r;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         exp_r = pending_rsp.pop_front();
         if (got.out_index !== exp_r.out_index)
            $display("%0t: out_index exp %0d got %0d", $time, exp_r.out_index, got.out_index);
         if (got.out_city !== exp_r.out_city)
            $display("%0t: out_city exp %0d got %0d", $time, exp_r.out_city, got.out_city);
         if (got.final_cost !== exp_r.final_cost)
            $display("%0t: final_cost exp %0d got %0d", $time, exp_r.final_cost,
                     got.final_cost);
         if (got.last !== exp_r.last)
            $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
         if (got !== exp_r) errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [1:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tour_scoreboard tour_sb;
   int          idle_pct;
   int          stall_count;

   localparam int STALL_LIMIT = 2000000;
   localparam int USED_CITIES = 8;
   localparam logic [1:0] ADDR_NUM_CITIES = 2'd0;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   two_opt_tour_improver_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tour_sb.check_result(rsp_payload);
         if (rsp_valid || (start && !busy)) begin
            stall_count <= 0;
         end else begin
            stall_count <= stall_count + 1;
         end
         if (stall_count > STALL_LIMIT) begin
            $display("two_opt_tour_improver_core test failed");
            $finish;
         end
      end
   end

   // one transfer, with random idle cycles ahead of it; start stays high after
   // the transfer until the next driving task sets it
   task automatic send_item(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      tour_sb.note_item(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tour_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_num_cities(logic [6:0] v);
      start <= 1'b0;
      psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_NUM_CITIES; pwdata <= {25'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      tour_sb.city_count = 32'(v);
   endtask

   function automatic req_type mk_cost(int a, int b, int c);
      req_type r;
      r = {$urandom, $urandom};
      r.func = FUNC_COST; r.from_city = 6'(a); r.to_city = 6'(b); r.edge_cost = 16'(c);
      return r;
   endfunction

   function automatic req_type mk_tour(int p, int c);
      req_type r;
      r = {$urandom, $urandom};
      r.func = FUNC_TOUR; r.tour_index = 6'(p); r.tour_city = 6'(c);
      return r;
   endfunction

   function automatic req_type mk_run(int sc);
      req_type r;
      r = {$urandom, $urandom};
      r.func = FUNC_RUN; r.start_cost = 22'(sc);
      return r;
   endfunction

   // tours only hold the first few cities, so this corner covers every matrix read
   task automatic load_costs(int maxc);
      for (int a = 0; a < USED_CITIES; a++)
         for (int b = 0; b < USED_CITIES; b++)
            send_item(mk_cost(a, b, $urandom_range(maxc)));
   endtask

   // costs plus all 64 tour positions so no run reads unwritten state
   task automatic load_all(int maxc);
      load_costs(maxc);
      for (int k = 0; k < 64; k++) send_item(mk_tour(k, $urandom_range(USED_CITIES - 1)));
   endtask

   // a small random phase: runs, cost loads, tour edits and some noise
   task automatic random_phase(int count);
      req_type r;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(9);
         if (sel < 3) r = mk_run($urandom_range(4194303));
         else if (sel < 4) r = mk_run($urandom_range(300));
         else if (sel < 7)
            r = mk_cost($urandom_range(USED_CITIES - 1), $urandom_range(USED_CITIES - 1),
                        $urandom);
         else if (sel < 9) r = mk_tour($urandom_range(63), $urandom_range(USED_CITIES - 1));
         else begin
            r = {$urandom, $urandom};
            r.func = FUNC_UNUSED;
         end
         send_item(r);
      end
   endtask

   initial begin
      tour_sb = new();
      reset = 1'b1; start = 1'b0; req_payload = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      stall_count = 0; idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full load, then extreme costs and starts at several sizes
      load_all(65535);
      write_num_cities(7'd3);
      send_item(mk_run(0));
      send_item(mk_run(4194303));
      send_item(mk_cost(63, 63, 65535));
      send_item(mk_cost(0, 0, 0));
      drain();
      write_num_cities(7'd4);
      send_item(mk_run(1));
      send_item(mk_run(4194303));
      drain();
      write_num_cities(7'd64);
      send_item(mk_run(4194303));
      drain();

      // random phases over several city counts and idle patterns
      write_num_cities(7'd6);
      idle_pct = 33;
      random_phase(50);
      drain();
      write_num_cities(7'd127);
      load_costs(15);
      write_num_cities(7'd5);
      idle_pct = 52;
      random_phase(50);
      drain();
      write_num_cities(7'd0);
      idle_pct = 0;
      random_phase(30);
      drain();
      write_num_cities(7'd8);
      random_phase(20);
      drain();

      if (tour_sb.errors == 0 && tour_sb.pending_rsp.size() == 0) begin
         $display("two_opt_tour_improver_core test passed");
      end else begin
         $display("two_opt_tour_improver_core test failed");
      end
      $finish;
   end

endmodule
